[hw/rtl/gpsc_pkg.sv]
`default_nettype none

package gpsc_pkg;

    // gauge count and reset pot positions
    localparam int GAUGES          = 16;
    localparam int INIT_AMP_POS    = 128;
    localparam int INIT_BRIDGE_POS = 128;

    // entry index width, at least one bit
    localparam int GIDX_W = (GAUGES > 1) ? $clog2(GAUGES) : 1;

    localparam int POS_W  = 8;
    localparam int TGT_W  = 10;
    localparam int TOL_W  = 10;
    localparam int SMP_W  = 10;
    localparam int CFG_W  = 10;
    localparam int CIDX_W = 2;

    localparam logic [TGT_W-1:0] TGT_MIN_RST = TGT_W'(15);
    localparam logic [TGT_W-1:0] TGT_AMP_RST = TGT_W'(300);
    localparam logic [TOL_W-1:0] TOL_RST     = TOL_W'(5);
    localparam logic [POS_W-1:0] POS_MAX     = '1;

    typedef enum logic [3:0] {
        K_BRIDGE_MIN = 4'd0,
        K_AMP_STEP   = 4'd1,
        K_BRIDGE_AMP = 4'd2,
        K_CLR_BRIDGE = 4'd3,
        K_CLR_AMP    = 4'd4,
        K_WR_BRIDGE  = 4'd5,
        K_WR_AMP     = 4'd6,
        K_WR_TGT_MIN = 4'd7,
        K_WR_TGT_AMP = 4'd8
    } t_kind;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TOL_NO_AMP   = 2'd0,
        CFG_TOL_WITH_AMP = 2'd1,
        CFG_SKIP_BROKEN  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_CALC = 1'b1
    } t_state;

    typedef struct packed {
        logic [3:0]       kind;
        logic [3:0]       gauge;
        logic [SMP_W-1:0] sample;
        logic [TGT_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] amp_wiper;
        logic [POS_W-1:0] bridge_wiper;
        logic             bridge_done;
        logic             amp_done;
        logic             broken;
    } t_out;

    // one gauge record as held in the state memory
    typedef struct packed {
        logic [POS_W-1:0] bridge_pos;
        logic [POS_W-1:0] amp_pos;
        logic [TGT_W-1:0] tgt_min;
        logic [TGT_W-1:0] tgt_amp;
        logic             bridge_done;
        logic             amp_done;
        logic             broken;
    } t_entry;

    localparam t_entry ENTRY_RST = '{
        bridge_pos:  POS_W'(INIT_BRIDGE_POS),
        amp_pos:     POS_W'(INIT_AMP_POS),
        tgt_min:     TGT_MIN_RST,
        tgt_amp:     TGT_AMP_RST,
        bridge_done: 1'b0,
        amp_done:    1'b0,
        broken:      1'b0
    };

    typedef struct packed {
        logic              rd_en;
        logic [GIDX_W-1:0] rd_idx;
        logic              wr_en;
        logic [GIDX_W-1:0] wr_idx;
    } t_mem_ctl;

    typedef struct packed {
        logic [TOL_W-1:0] tol_no_amp;
        logic [TOL_W-1:0] tol_with_amp;
        logic             skip_broken;
    } t_cfg;

endpackage

`default_nettype wire

[hw/rtl/gpsc_mem.sv]
`default_nettype none

module gpsc_mem
    import gpsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_ctl i_ctl,
    input  wire t_entry   i_wr_data,
    output t_entry        o_rd_data
);

    t_entry            r_mem [GAUGES];
    logic [GAUGES-1:0] r_valid;
    t_entry            r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_idx] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_idx];
        end
    end

    // written-once bits stand in for the reset values of the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_idx] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_ctl.rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : ENTRY_RST;

endmodule

`default_nettype wire

[hw/rtl/gpsc_step.sv]
`default_nettype none

module gpsc_step
    import gpsc_pkg::*;
(
    input  wire t_in    i_item,
    input  wire t_entry i_entry,
    input  wire t_cfg   i_cfg,
    output t_entry      o_entry,
    output t_out        o_res,
    output logic        o_in_range
);

    logic                  step;
    logic                  use_amp_pot;
    logic [TGT_W-1:0]      target;
    logic [TOL_W-1:0]      tol;
    logic [POS_W-1:0]      pos;
    logic                  stage_done;
    logic signed [SMP_W+1:0] s_smp;
    logic signed [SMP_W+1:0] s_lo;
    logic signed [SMP_W+1:0] s_hi;
    logic [POS_W-1:0]      n_pos;
    logic                  n_done;
    logic                  n_bad;
    t_entry                upd;

    assign o_in_range = 32'(i_item.gauge) < 32'(GAUGES);

    always_comb begin
        step        = 1'b0;
        use_amp_pot = 1'b0;
        target      = i_entry.tgt_amp;
        tol         = i_cfg.tol_with_amp;
        case (t_kind'(i_item.kind))
            K_BRIDGE_MIN: begin
                step   = 1'b1;
                target = i_entry.tgt_min;
                tol    = i_cfg.tol_no_amp;
            end
            K_AMP_STEP: begin
                step        = 1'b1;
                use_amp_pot = 1'b1;
            end
            K_BRIDGE_AMP: begin
                step = 1'b1;
            end
            default: begin
                step = 1'b0;
            end
        endcase
    end

    assign pos        = use_amp_pot ? i_entry.amp_pos : i_entry.bridge_pos;
    assign stage_done = use_amp_pot ? i_entry.amp_done : i_entry.bridge_done;

    // band bounds are signed and unclipped
    assign s_smp = $signed({2'b00, i_item.sample});
    assign s_lo  = $signed({2'b00, target}) - $signed({2'b00, tol});
    assign s_hi  = $signed({2'b00, target}) + $signed({2'b00, tol});

    always_comb begin
        n_pos  = pos;
        n_done = stage_done;
        n_bad  = i_entry.broken;
        if (!(stage_done || (i_cfg.skip_broken && i_entry.broken))) begin
            if (s_smp < s_lo) begin
                n_pos = pos - POS_W'(1);
                if (pos == '0) begin
                    n_done = 1'b1;
                    n_bad  = 1'b1;
                end
            end else if (s_smp > s_hi) begin
                n_pos = pos + POS_W'(1);
                if (pos == POS_MAX) begin
                    n_done = 1'b1;
                    n_bad  = 1'b1;
                end
            end else begin
                n_done = 1'b1;
            end
        end
    end

    always_comb begin
        upd = i_entry;
        if (step) begin
            upd.broken = n_bad;
            if (use_amp_pot) begin
                upd.amp_pos  = n_pos;
                upd.amp_done = n_done;
            end else begin
                upd.bridge_pos  = n_pos;
                upd.bridge_done = n_done;
            end
        end else begin
            case (t_kind'(i_item.kind))
                K_CLR_BRIDGE: upd.bridge_done = 1'b0;
                K_CLR_AMP:    upd.amp_done    = 1'b0;
                K_WR_BRIDGE:  upd.bridge_pos  = i_item.value[POS_W-1:0];
                K_WR_AMP:     upd.amp_pos     = i_item.value[POS_W-1:0];
                K_WR_TGT_MIN: upd.tgt_min     = i_item.value;
                K_WR_TGT_AMP: upd.tgt_amp     = i_item.value;
                default:      upd             = i_entry;
            endcase
        end
    end

    assign o_entry = upd;

    always_comb begin
        o_res = '0;
        if (o_in_range) begin
            o_res.amp_wiper    = (t_kind'(i_item.kind) == K_BRIDGE_MIN) ? POS_MAX : upd.amp_pos;
            o_res.bridge_wiper = upd.bridge_pos;
            o_res.bridge_done  = upd.bridge_done;
            o_res.amp_done     = upd.amp_done;
            o_res.broken       = upd.broken;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gauge_pot_step_calibrator.sv]
// channel   | direction | handshake                 | beat
// ----------+-----------+---------------------------+--------------------------------
// in        | input     | i_in_valid / o_in_stall   | t_in: kind, gauge, sample, value
// out       | output    | o_out_valid / i_out_stall | t_out: wipers and flags
// cfg       | input     | i_cfg_we, no handshake    | i_cfg_idx, i_cfg_data
//
// an item is read from memory on accept, then modified and written back
// the read-modify-write of the gauge record holds off a new item until the last one is written back
// synchronous active-low reset; no clearing pass, per-entry written bits give reset values
// a stalled result sits in the output register, the next result in a hold register
// new beats are refused only while a result is in flight or the hold register is full
`default_nettype none

module gauge_pot_step_calibrator
    import gpsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in               i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out                   o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_state   r_state;
    t_state   n_state;
    t_in      r_item;
    t_cfg     r_cfg;
    t_mem_ctl mem_ctl;
    t_entry   rd_entry;
    t_entry   wr_entry;
    t_out     res;
    logic     in_range;
    logic     in_acc;
    logic     out_free;
    t_out     r_out;
    logic     r_out_v;
    t_out     r_hold;
    logic     r_hold_v;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tol_no_amp   <= TOL_RST;
            r_cfg.tol_with_amp <= TOL_RST;
            r_cfg.skip_broken  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOL_NO_AMP:   r_cfg.tol_no_amp   <= i_cfg_data[TOL_W-1:0];
                CFG_TOL_WITH_AMP: r_cfg.tol_with_amp <= i_cfg_data[TOL_W-1:0];
                CFG_SKIP_BROKEN:  r_cfg.skip_broken  <= i_cfg_data[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // busy while a record is being modified and written back; hold full also blocks
    assign o_in_stall = (r_state != S_IDLE) || r_hold_v;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        mem_ctl.rd_en  = 1'b0;
        mem_ctl.rd_idx = GIDX_W'(i_in_data.gauge);
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.wr_idx = GIDX_W'(r_item.gauge);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    mem_ctl.rd_en = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                // write back only for a gauge that exists
                mem_ctl.wr_en = in_range;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
    end

    gpsc_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_data (wr_entry),
        .o_rd_data (rd_entry)
    );

    gpsc_step u_step (
        .i_item     (r_item),
        .i_entry    (rd_entry),
        .i_cfg      (r_cfg),
        .o_entry    (wr_entry),
        .o_res      (res),
        .o_in_range (in_range)
    );

    // output register with a one-deep hold behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (r_state == S_CALC) begin
                if (out_free) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_hold_v <= 1'b1;
                end
            end else if (r_hold_v && out_free) begin
                r_out_v  <= 1'b1;
                r_hold_v <= 1'b0;
            end else if (out_free) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            if (out_free) begin
                r_out <= res;
            end else begin
                r_hold <= res;
            end
        end else if (r_hold_v && out_free) begin
            r_out <= r_hold;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // an accepted beat always goes to the modify cycle next
    a_acc_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CALC))
        else $error("accepted beat did not reach modify cycle");

    // hold register fills only behind a waiting result
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_out_v)
        else $error("hold full with output empty");

    // no result in flight while the hold register is full
    a_calc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> !r_hold_v)
        else $error("result computed with hold full");

    // memory writes only in the modify cycle, never with a read
    a_wr_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> ((r_state == S_CALC) && !mem_ctl.rd_en))
        else $error("memory write outside modify cycle");

endmodule

`default_nettype wire

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpsc_pkg::*;

    // kinds the block does not decode, still answered with the gauge's record
    localparam logic [3:0]        K_SPARE_LO = 4'd9;
    localparam logic [3:0]        K_SPARE_HI = 4'd15;
    // register index with no register behind it
    localparam logic [CIDX_W-1:0] CFG_SPARE  = 2'd3;

    localparam int HOLD_CYCLES  = 250;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;     // settle time once the last result is back
    localparam int ITEM_TOTAL   = 1350;

    // mirror of the gauge records and the tolerance registers, plus the
    // queue of results the block still owes
    class calib_tracker;
        logic [POS_W-1:0] bridge_pos  [GAUGES];
        logic [POS_W-1:0] amp_pos     [GAUGES];
        logic [TGT_W-1:0] tgt_min     [GAUGES];
        logic [TGT_W-1:0] tgt_amp     [GAUGES];
        logic             bridge_done [GAUGES];
        logic             amp_done    [GAUGES];
        logic             broken      [GAUGES];
        logic [TOL_W-1:0] tol_no_amp;
        logic [TOL_W-1:0] tol_with_amp;
        logic             skip_broken;
        t_out             due_reports [$];
        int               faults;
        int               shown;

        function new();
            for (int g = 0; g < GAUGES; g++) begin
                bridge_pos[g]  = POS_W'(INIT_BRIDGE_POS);
                amp_pos[g]     = POS_W'(INIT_AMP_POS);
                tgt_min[g]     = TGT_MIN_RST;
                tgt_amp[g]     = TGT_AMP_RST;
                bridge_done[g] = 1'b0;
                amp_done[g]    = 1'b0;
                broken[g]      = 1'b0;
            end
            tol_no_amp   = TOL_RST;
            tol_with_amp = TOL_RST;
            skip_broken  = 1'b0;
            faults       = 0;
            shown        = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_TOL_NO_AMP:   tol_no_amp   = d[TOL_W-1:0];
                CFG_TOL_WITH_AMP: tol_with_amp = d[TOL_W-1:0];
                CFG_SKIP_BROKEN:  skip_broken  = d[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // apply one accepted input beat and queue the result it owes
        function void take_item(t_in b);
            int               g;
            int               s;
            int               lo;
            int               hi;
            logic [POS_W-1:0] pos;
            logic             done;
            logic             on_amp;
            logic             active;
            logic [TGT_W-1:0] tgt;
            logic [TOL_W-1:0] tol;
            t_out             r;
            g      = int'(b.gauge);
            r      = '0;
            active = 1'b1;
            on_amp = 1'b0;
            pos    = '0;
            done   = 1'b0;
            tgt    = '0;
            tol    = '0;
            if (g < GAUGES) begin
                case (b.kind)
                    K_BRIDGE_MIN: begin
                        pos  = bridge_pos[g];
                        done = bridge_done[g];
                        tgt  = tgt_min[g];
                        tol  = tol_no_amp;
                    end
                    K_AMP_STEP: begin
                        on_amp = 1'b1;
                        pos    = amp_pos[g];
                        done   = amp_done[g];
                        tgt    = tgt_amp[g];
                        tol    = tol_with_amp;
                    end
                    K_BRIDGE_AMP: begin
                        pos  = bridge_pos[g];
                        done = bridge_done[g];
                        tgt  = tgt_amp[g];
                        tol  = tol_with_amp;
                    end
                    K_CLR_BRIDGE: begin
                        bridge_done[g] = 1'b0;
                        active         = 1'b0;
                    end
                    K_CLR_AMP: begin
                        amp_done[g] = 1'b0;
                        active      = 1'b0;
                    end
                    K_WR_BRIDGE: begin
                        bridge_pos[g] = b.value[POS_W-1:0];
                        active        = 1'b0;
                    end
                    K_WR_AMP: begin
                        amp_pos[g] = b.value[POS_W-1:0];
                        active     = 1'b0;
                    end
                    K_WR_TGT_MIN: begin
                        tgt_min[g] = b.value;
                        active     = 1'b0;
                    end
                    K_WR_TGT_AMP: begin
                        tgt_amp[g] = b.value;
                        active     = 1'b0;
                    end
                    default: active = 1'b0;
                endcase
                // a done stage, or a broken gauge under skip, stays put
                if (active && !done && !(skip_broken && broken[g])) begin
                    s  = int'(b.sample);
                    lo = int'(tgt) - int'(tol);
                    hi = int'(tgt) + int'(tol);
                    if (s < lo) begin
                        if (pos == '0) begin
                            pos       = POS_MAX;
                            done      = 1'b1;
                            broken[g] = 1'b1;
                        end else begin
                            pos = pos - 1'b1;
                        end
                    end else if (s > hi) begin
                        if (pos == POS_MAX) begin
                            pos       = '0;
                            done      = 1'b1;
                            broken[g] = 1'b1;
                        end else begin
                            pos = pos + 1'b1;
                        end
                    end else begin
                        done = 1'b1;
                    end
                    if (on_amp) begin
                        amp_pos[g]  = pos;
                        amp_done[g] = done;
                    end else begin
                        bridge_pos[g]  = pos;
                        bridge_done[g] = done;
                    end
                end
                r.amp_wiper    = (b.kind == K_BRIDGE_MIN) ? POS_MAX : amp_pos[g];
                r.bridge_wiper = bridge_pos[g];
                r.bridge_done  = bridge_done[g];
                r.amp_done     = amp_done[g];
                r.broken       = broken[g];
            end
            due_reports.push_back(r);
        endfunction

        // compare one accepted result beat with the oldest owed result
        function void match_report(t_out got);
            t_out want;
            if (due_reports.size() == 0) begin
                faults++;
                if (shown < 10) begin
                    $display("unexpected result beat: amp %0d bridge %0d bd %0b ad %0b brk %0b",
                             got.amp_wiper, got.bridge_wiper, got.bridge_done,
                             got.amp_done, got.broken);
                    shown++;
                end
            end else begin
                want = due_reports.pop_front();
                if (got.amp_wiper !== want.amp_wiper || got.bridge_wiper !== want.bridge_wiper ||
                    got.bridge_done !== want.bridge_done || got.amp_done !== want.amp_done ||
                    got.broken !== want.broken) begin
                    faults++;
                    if (shown < 10) begin
                        $display("mismatch: exp amp %0d bridge %0d bd %0b ad %0b brk %0b",
                                 want.amp_wiper, want.bridge_wiper, want.bridge_done,
                                 want.amp_done, want.broken);
                        $display("          got amp %0d bridge %0d bd %0b ad %0b brk %0b",
                                 got.amp_wiper, got.bridge_wiper, got.bridge_done,
                                 got.amp_done, got.broken);
                        shown++;
                    end
                end
            end
        endfunction
    endclass

    // dut inputs, all known from time zero
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in               in_beat   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out              out_beat;
    logic              cfg_we    = 1'b0;
    logic [CIDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    calib_tracker tracker;
    int           sent     = 0;
    bit           tx_gaps  = 1'b1;   // sender inserts idle bursts
    bit           rx_gaps  = 1'b1;   // receiver inserts stall bursts
    bit           hold_req = 1'b0;   // ask receiver for one long hold-off

    gauge_pot_step_calibrator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_in make_item(logic [3:0] k, logic [3:0] g, logic [SMP_W-1:0] s,
                                      logic [TGT_W-1:0] v);
        t_in it;
        it.kind   = k;
        it.gauge  = g;
        it.sample = s;
        it.value  = v;
        return it;
    endfunction

    // narrow bands or the extremes, now and then any width
    function automatic logic [TOL_W-1:0] pick_tol();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2, 3:    return TOL_W'($urandom_range(0, 40));
            default: return TOL_W'($urandom);
        endcase
    endfunction

    // offer one input beat, optionally after an idle burst, and hold it until taken
    task automatic offer_item(t_in it);
        int gap;
        @(negedge clk);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= it;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        tracker.take_item(it);
        sent++;
    endtask

    // stop offering and wait until every owed result is back and the block settles
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all registers while idle, plus the index with no register behind it
    task automatic apply_config(logic [TOL_W-1:0] t0, logic [TOL_W-1:0] t1, logic sk);
        logic [CFG_W-1:0] skip_word;
        logic [CFG_W-1:0] spare_word;
        skip_word    = CFG_W'($urandom);
        skip_word[0] = sk;
        spare_word   = CFG_W'($urandom);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TOL_NO_AMP;
        cfg_data <= CFG_W'(t0);
        @(negedge clk);
        cfg_idx  <= CFG_TOL_WITH_AMP;
        cfg_data <= CFG_W'(t1);
        @(negedge clk);
        cfg_idx  <= CFG_SKIP_BROKEN;
        cfg_data <= skip_word;
        @(negedge clk);
        cfg_idx  <= CFG_SPARE;
        cfg_data <= spare_word;
        @(negedge clk);
        cfg_we   <= 1'b0;
        tracker.set_reg(CFG_TOL_NO_AMP, CFG_W'(t0));
        tracker.set_reg(CFG_TOL_WITH_AMP, CFG_W'(t1));
        tracker.set_reg(CFG_SKIP_BROKEN, skip_word);
        tracker.set_reg(CFG_SPARE, spare_word);
    endtask

    // one calibration run on a gauge: clear the stage, maybe preset pot and
    // target, then a string of steps with samples around the band
    task automatic run_sequence();
        int               g;
        int               stage;
        int               n;
        int               tgt;
        int               tol;
        int               off;
        int               s;
        logic [3:0]       step_kind;
        logic [3:0]       clr_kind;
        logic [3:0]       pot_kind;
        logic [3:0]       tgt_kind;
        logic [TGT_W-1:0] v;
        g     = $urandom_range(0, GAUGES - 1);
        stage = $urandom_range(0, 2);
        case (stage)
            0: begin
                step_kind = K_BRIDGE_MIN;
                clr_kind  = K_CLR_BRIDGE;
                pot_kind  = K_WR_BRIDGE;
                tgt_kind  = K_WR_TGT_MIN;
            end
            1: begin
                step_kind = K_AMP_STEP;
                clr_kind  = K_CLR_AMP;
                pot_kind  = K_WR_AMP;
                tgt_kind  = K_WR_TGT_AMP;
            end
            default: begin
                step_kind = K_BRIDGE_AMP;
                clr_kind  = K_CLR_BRIDGE;
                pot_kind  = K_WR_BRIDGE;
                tgt_kind  = K_WR_TGT_AMP;
            end
        endcase
        offer_item(make_item(clr_kind, g, SMP_W'($urandom), TGT_W'($urandom)));
        if ($urandom_range(0, 1) == 1) begin
            // pot near the rails so that run-outs happen often
            v = TGT_W'($urandom);
            case ($urandom_range(0, 5))
                0: v[POS_W-1:0] = 8'h00;
                1: v[POS_W-1:0] = 8'h01;
                2: v[POS_W-1:0] = 8'hfe;
                3: v[POS_W-1:0] = 8'hff;
                default: ;
            endcase
            offer_item(make_item(pot_kind, g, SMP_W'($urandom), v));
        end
        if ($urandom_range(0, 2) == 0) begin
            v = TGT_W'($urandom);
            if ($urandom_range(0, 3) == 0) v = ($urandom_range(0, 1) == 1) ? '1 : '0;
            offer_item(make_item(tgt_kind, g, SMP_W'($urandom), v));
        end
        n = $urandom_range(2, 12);
        for (int j = 0; j < n; j++) begin
            tgt = (stage == 0) ? int'(tracker.tgt_min[g]) : int'(tracker.tgt_amp[g]);
            tol = (stage == 0) ? int'(tracker.tol_no_amp) : int'(tracker.tol_with_amp);
            if ($urandom_range(0, 3) == 0) begin
                s = $urandom_range(0, 1023);
            end else begin
                off = $urandom_range(0, 2 * tol + 8);
                s   = tgt + off - tol - 4;
                if (s < 0) s = 0;
                if (s > 1023) s = 1023;
            end
            offer_item(make_item(step_kind, g, SMP_W'(s), TGT_W'($urandom)));
        end
    endtask

    // well-formed runs most of the time, short bursts of raw noise otherwise
    task automatic run_random(int upto);
        int n;
        while (sent < upto) begin
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) offer_item(make_item(4'($urandom), 4'($urandom),
                                                SMP_W'($urandom), TGT_W'($urandom)));
            end else begin
                run_sequence();
            end
        end
    endtask

    // receiver: stall bursts, and one long hold-off on request
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
                hold_req   = 1'b0;
                stall_left = 0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // result beats are taken at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            tracker.match_report(out_beat);
        end
    end

    initial begin : main
        tracker = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings: target 15 / 300, band half-width 5
        offer_item(make_item(K_BRIDGE_MIN, 4'd0, 10'h3ff, 10'h000));  // above band, up
        offer_item(make_item(K_BRIDGE_MIN, 4'd0, 10'h000, 10'h3ff));  // below band, down
        offer_item(make_item(K_BRIDGE_MIN, 4'd0, 10'd15, 10'd0));     // inside, done
        offer_item(make_item(K_BRIDGE_MIN, 4'd0, 10'h3ff, 10'd0));    // already done
        offer_item(make_item(K_CLR_BRIDGE, 4'd0, 10'h3ff, 10'h3ff));
        offer_item(make_item(K_WR_BRIDGE, 4'd1, 10'd0, 10'h300));     // pot at 0
        offer_item(make_item(K_BRIDGE_MIN, 4'd1, 10'd0, 10'd0));      // run out below 0
        offer_item(make_item(K_WR_AMP, 4'd2, 10'd0, 10'h3ff));        // pot at 255
        offer_item(make_item(K_AMP_STEP, 4'd2, 10'h3ff, 10'd0));      // run out above 255
        offer_item(make_item(K_CLR_AMP, 4'd2, 10'd0, 10'd0));
        offer_item(make_item(K_AMP_STEP, 4'd2, 10'd300, 10'd0));      // broken but not skipped
        offer_item(make_item(K_WR_TGT_MIN, 4'd3, 10'd0, 10'd0));
        offer_item(make_item(K_BRIDGE_MIN, 4'd3, 10'd0, 10'd0));      // negative lower bound
        offer_item(make_item(K_WR_TGT_AMP, 4'd4, 10'd0, 10'h3ff));
        offer_item(make_item(K_BRIDGE_AMP, 4'd4, 10'h3ff, 10'd0));    // band at the top
        offer_item(make_item(K_BRIDGE_AMP, 4'd5, 10'd0, 10'd0));
        offer_item(make_item(K_AMP_STEP, 4'd15, 10'd512, 10'd0));
        offer_item(make_item(K_SPARE_LO, 4'd15, 10'h3ff, 10'h3ff));   // undecoded kinds
        offer_item(make_item(K_SPARE_HI, 4'd15, 10'h2aa, 10'h155));
        offer_item(make_item(K_WR_TGT_AMP, 4'd15, 10'd0, 10'd0));
        offer_item(make_item(K_BRIDGE_AMP, 4'd15, 10'd0, 10'd0));

        // zero-width band for kind 0, widest band for the others, skip broken
        apply_config('0, '1, 1'b1);
        offer_item(make_item(K_CLR_BRIDGE, 4'd1, 10'd0, 10'd0));
        offer_item(make_item(K_BRIDGE_MIN, 4'd1, 10'd0, 10'd0));      // skipped, broken
        offer_item(make_item(K_BRIDGE_MIN, 4'd6, 10'd15, 10'd0));     // exact hit
        offer_item(make_item(K_BRIDGE_MIN, 4'd7, 10'd16, 10'd0));     // one off
        offer_item(make_item(K_BRIDGE_AMP, 4'd7, 10'h3ff, 10'd0));
        apply_config('1, '0, 1'b0);
        offer_item(make_item(K_BRIDGE_MIN, 4'd1, 10'd0, 10'd0));      // broken, no skip

        // random part; first phase carries the long receiver hold-off
        apply_config(pick_tol(), pick_tol(), 1'($urandom));
        hold_req = 1'b1;
        run_random(300);

        apply_config('0, '0, 1'b1);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(450);

        apply_config('1, '1, 1'b0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random(650);

        while (sent < ITEM_TOTAL - 150) begin
            apply_config(pick_tol(), pick_tol(), 1'($urandom));
            tx_gaps = 1'($urandom);
            rx_gaps = 1'($urandom);
            run_random(sent + 120);
        end

        // closing stretch at full rate on both sides
        apply_config(pick_tol(), pick_tol(), 1'($urandom));
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(ITEM_TOTAL);
        drain();

        if (tracker.faults == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/gpsc_pkg.sv
hw/rtl/gpsc_mem.sv
hw/rtl/gpsc_step.sv
hw/rtl/gauge_pot_step_calibrator.sv
dv/tb.sv
